// ===== rtl/clle_pkg.sv =====
`default_nettype none
package clle_pkg;

  localparam int unsigned DEPTH_DEF      = 256;
  localparam int unsigned NUM_LISTS_DEF  = 4;
  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned LINK_W         = 9;

  // byte address of the empty_marker register
  localparam logic [1:0] CFG_ADDR_MARKER = 2'd0;

  typedef enum logic [2:0] {
    ACT_INS_FRONT  = 3'd0,
    ACT_INS_REAR   = 3'd1,
    ACT_INS_SORTED = 3'd2,
    ACT_INS_POS    = 3'd3,
    ACT_DEL_FRONT  = 3'd4,
    ACT_DEL_REAR   = 3'd5,
    ACT_DEL_POS    = 3'd6,
    ACT_READ_NODE  = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  localparam logic [LINK_W-1:0] NIL = '1;

  // memory port controls
  typedef struct packed {
    logic rd_en;
    logic data_we;
    logic link_we;
  } store_ctl_t;

  // map a link outside 0..depth-1 to end of list
  function automatic logic [LINK_W-1:0] norm(input logic [LINK_W-1:0] v,
                                             input int unsigned depth);
    logic ok;
    ok = !v[LINK_W-1] && (int'(v) < int'(depth));
    return ok ? v : NIL;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/clle_node_store.sv =====
`default_nettype none
module clle_node_store #(
  parameter int unsigned DEPTH      = clle_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = clle_pkg::DATA_WIDTH_DEF,
  localparam int unsigned AW        = $clog2(DEPTH)
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  clle_pkg::store_ctl_t            ctl,
  input  wire [AW-1:0]                    rd_addr,
  input  wire [AW-1:0]                    wr_addr,
  input  wire [DATA_WIDTH-1:0]            wr_data,
  input  wire [clle_pkg::LINK_W-1:0]      wr_link,
  output logic [DATA_WIDTH-1:0]           rd_data,
  output logic [clle_pkg::LINK_W-1:0]     rd_link
);

  logic [DATA_WIDTH-1:0]       data_mem [DEPTH];
  logic [clle_pkg::LINK_W-1:0] link_mem [DEPTH];
  logic [DEPTH-1:0]            vld_r;
  logic [DATA_WIDTH-1:0]       data_q_r;
  logic [clle_pkg::LINK_W-1:0] link_q_r;
  logic                        v_r;
  logic [AW-1:0]               addr_q_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (ctl.data_we) begin
      data_mem[wr_addr] <= wr_data;
    end
    if (ctl.link_we) begin
      link_mem[wr_addr] <= wr_link;
    end
    if (ctl.rd_en) begin
      data_q_r <= data_mem[rd_addr];
      link_q_r <= link_mem[rd_addr];
      addr_q_r <= rd_addr;
    end
  end

  // track written entries; a data write always comes with a link write,
  // so one mark per entry covers both, and unwritten ones read as reset contents
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      v_r   <= 1'b0;
    end else begin
      if (ctl.link_we) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        v_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = v_r ? data_q_r : '0;
  assign rd_link = v_r ? link_q_r
                       : clle_pkg::LINK_W'(addr_q_r) - clle_pkg::LINK_W'(1);

endmodule
`default_nettype wire

// ===== rtl/cursor_linked_list_engine_top.sv =====
`default_nettype none
// Linked-list engine: a node store of DEPTH entries holds NUM_LISTS singly
// linked lists plus a free list.
// Input channel (in_*): one action per transaction (insert front, rear,
// sorted or at a position, delete front, rear or at a position, read node).
// Output channel (out_*): exactly one result transaction per action, with
// status, node index touched, list head after the action and read data.
// Front actions and read_node walk no nodes; rear, sorted and positional
// actions walk the list, up to DEPTH nodes, each node read in S_WALK and
// checked in S_WAIT. The walk is bound by the single read port of the node
// store, whose read data arrives in the cycle after the address.
// One action is in flight at a time; the next is taken in the idle cycle after
// the previous result sits in the output register.
// Reset (rst_n, synchronous): every list empty, free list runs down from
// index DEPTH-1, all node data reads as zero, empty_marker is zero. No
// clearing pass is needed; the block accepts actions right after reset.
// A stalled receiver holds the result in the output register; the engine
// waits in its final state until that register frees.
// Configuration: APB register 0 (address 0) is empty_marker.
module cursor_linked_list_engine_top #(
  parameter int unsigned DEPTH      = clle_pkg::DEPTH_DEF,
  parameter int unsigned NUM_LISTS  = clle_pkg::NUM_LISTS_DEF,
  parameter int unsigned DATA_WIDTH = clle_pkg::DATA_WIDTH_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire [2:0]         in_action,
  input  wire [1:0]         in_list_id,
  input  wire signed [31:0] in_item,
  input  wire [7:0]         in_position,
  input  wire [7:0]         in_node_addr,
  output logic              out_valid,
  input  wire               out_ready,
  output logic [1:0]        out_status,
  output logic signed [8:0] out_node_index,
  output logic signed [8:0] out_list_head,
  output logic signed [31:0] out_data_out,
  output logic signed [8:0] out_next_out,
  input  wire               cfg_psel,
  input  wire               cfg_penable,
  input  wire               cfg_pwrite,
  input  wire [1:0]         cfg_paddr,
  input  wire [31:0]        cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned LW = clle_pkg::LINK_W;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_WALK, S_WAIT, S_AL_RD, S_AL_WT,
    S_FR_RD, S_FR_WT, S_SETLK, S_RD_WT, S_DONE
  } state_t;

  state_t                 state_r, state_nxt;
  clle_pkg::action_t      act_r, act_nxt;
  logic [1:0]             lid_r, lid_nxt;
  logic signed [DATA_WIDTH-1:0] item_r, item_nxt;
  logic [7:0]             pos_r, pos_nxt;
  logic [7:0]             addr_r, addr_nxt;
  logic [LW-1:0]          cur_r, cur_nxt;
  logic [LW-1:0]          prev_r, prev_nxt;
  logic [LW-1:0]          steps_r, steps_nxt;
  logic [7:0]             idx_r, idx_nxt;
  logic [LW-1:0]          lval_r, lval_nxt;
  logic [LW-1:0]          free_head_r, free_head_nxt;
  logic [LW-1:0]          heads_r [NUM_LISTS];
  logic [LW-1:0]          heads_nxt [NUM_LISTS];
  logic [1:0]             st_r, st_nxt;
  logic [LW-1:0]          nidx_r, nidx_nxt;
  logic [31:0]            dout_r, dout_nxt;
  logic [LW-1:0]          nxo_r, nxo_nxt;
  logic [31:0]            marker_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [1:0]             ost_r, ost_nxt;
  logic [LW-1:0]          onidx_r, onidx_nxt;
  logic [LW-1:0]          ohead_r, ohead_nxt;
  logic [31:0]            odout_r, odout_nxt;
  logic [LW-1:0]          onxt_r, onxt_nxt;

  clle_pkg::store_ctl_t   sctl;
  logic [AW-1:0]          s_rd_addr, s_wr_addr;
  logic [DATA_WIDTH-1:0]  s_wr_data, s_rd_data;
  logic [LW-1:0]          s_wr_link, s_rd_link;

  logic [LW-1:0]          head_sel;
  logic                   lid_ok;
  logic [LW-1:0]          rd_nl;
  logic signed [DATA_WIDTH-1:0] marker_d;
  logic signed [DATA_WIDTH-1:0] rd_sdata;
  logic                   is_ins, is_pos, is_bounded, walk_stop;

  clle_node_store #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (sctl),
    .rd_addr (s_rd_addr),
    .wr_addr (s_wr_addr),
    .wr_data (s_wr_data),
    .wr_link (s_wr_link),
    .rd_data (s_rd_data),
    .rd_link (s_rd_link)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      marker_r <= cfg_pwdata;
    end
  end
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == clle_pkg::CFG_ADDR_MARKER) ? marker_r : '0;

  // selected head and derived values
  always_comb begin
    head_sel = clle_pkg::NIL;
    for (int k = 0; k < int'(NUM_LISTS); k++) begin
      if (int'(lid_r) == k) begin
        head_sel = heads_r[k];
      end
    end
  end
  assign lid_ok   = int'(lid_r) < int'(NUM_LISTS);
  assign rd_nl    = clle_pkg::norm(s_rd_link, DEPTH);
  assign marker_d = DATA_WIDTH'(64'(signed'(marker_r)));
  assign rd_sdata = signed'(s_rd_data);
  assign is_ins   = (act_r == clle_pkg::ACT_INS_FRONT) || (act_r == clle_pkg::ACT_INS_REAR) ||
                    (act_r == clle_pkg::ACT_INS_SORTED) || (act_r == clle_pkg::ACT_INS_POS);
  assign is_pos   = (act_r == clle_pkg::ACT_INS_POS) || (act_r == clle_pkg::ACT_DEL_POS);
  assign is_bounded = (act_r == clle_pkg::ACT_INS_REAR) || (act_r == clle_pkg::ACT_INS_SORTED) ||
                      (act_r == clle_pkg::ACT_DEL_REAR);
  assign walk_stop = cur_r[LW-1] ||
                     (act_r == clle_pkg::ACT_INS_FRONT) || (act_r == clle_pkg::ACT_DEL_FRONT) ||
                     (is_bounded && (int'(steps_r) >= int'(DEPTH))) ||
                     (is_pos && (idx_r >= pos_r));

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    lid_nxt       = lid_r;
    item_nxt      = item_r;
    pos_nxt       = pos_r;
    addr_nxt      = addr_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    steps_nxt     = steps_r;
    idx_nxt       = idx_r;
    lval_nxt      = lval_r;
    free_head_nxt = free_head_r;
    heads_nxt     = heads_r;
    st_nxt        = st_r;
    nidx_nxt      = nidx_r;
    dout_nxt      = dout_r;
    nxo_nxt       = nxo_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ost_nxt       = ost_r;
    onidx_nxt     = onidx_r;
    ohead_nxt     = ohead_r;
    odout_nxt     = odout_r;
    onxt_nxt      = onxt_r;
    sctl          = '0;
    s_rd_addr     = cur_r[AW-1:0];
    s_wr_addr     = cur_r[AW-1:0];
    s_wr_data     = item_r;
    s_wr_link     = lval_r;
    in_ready      = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt   = clle_pkg::action_t'(in_action);
          lid_nxt   = in_list_id;
          item_nxt  = DATA_WIDTH'(64'(in_item));
          pos_nxt   = in_position;
          addr_nxt  = in_node_addr;
          state_nxt = S_START;
        end
      end
      S_START: begin
        st_nxt    = clle_pkg::ST_DONE;
        nidx_nxt  = clle_pkg::NIL;
        dout_nxt  = '0;
        nxo_nxt   = clle_pkg::NIL;
        cur_nxt   = clle_pkg::norm(head_sel, DEPTH);
        prev_nxt  = clle_pkg::NIL;
        steps_nxt = '0;
        idx_nxt   = 8'd1;
        if (!lid_ok) begin
          st_nxt    = clle_pkg::ST_RANGE;
          state_nxt = S_DONE;
        end else if (is_pos && ((pos_r == 8'd0) || (int'(pos_r) >= int'(DEPTH)))) begin
          st_nxt    = clle_pkg::ST_RANGE;
          state_nxt = S_DONE;
        end else if (is_ins && clle_pkg::norm(free_head_r, DEPTH) == clle_pkg::NIL) begin
          st_nxt    = clle_pkg::ST_FULL;
          state_nxt = S_DONE;
        end else if (act_r == clle_pkg::ACT_READ_NODE) begin
          if (int'(addr_r) >= int'(DEPTH)) begin
            st_nxt    = clle_pkg::ST_RANGE;
            state_nxt = S_DONE;
          end else begin
            sctl.rd_en = 1'b1;
            s_rd_addr  = addr_r[AW-1:0];
            state_nxt  = S_RD_WT;
          end
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (walk_stop) begin
          if (is_ins) begin
            state_nxt = S_AL_RD;
          end else if (cur_r[LW-1]) begin
            st_nxt    = clle_pkg::ST_EMPTY;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_FR_RD;
          end
        end else begin
          sctl.rd_en = 1'b1;
          state_nxt  = S_WAIT;
        end
      end
      S_WAIT: begin
        if (act_r == clle_pkg::ACT_INS_SORTED && !(rd_sdata < item_r)) begin
          state_nxt = S_AL_RD;
        end else if (act_r == clle_pkg::ACT_DEL_REAR && rd_nl[LW-1]) begin
          state_nxt = S_FR_RD;
        end else begin
          // advance one node
          prev_nxt  = cur_r;
          cur_nxt   = rd_nl;
          steps_nxt = steps_r + LW'(1);
          idx_nxt   = idx_r + 8'd1;
          state_nxt = S_WALK;
        end
      end
      S_AL_RD: begin
        sctl.rd_en = 1'b1;
        s_rd_addr  = free_head_r[AW-1:0];
        state_nxt  = S_AL_WT;
      end
      S_AL_WT: begin
        free_head_nxt = rd_nl;
        sctl.data_we  = 1'b1;
        sctl.link_we  = 1'b1;
        s_wr_addr     = free_head_r[AW-1:0];
        s_wr_data     = item_r;
        s_wr_link     = (act_r == clle_pkg::ACT_INS_REAR) ? clle_pkg::NIL : cur_r;
        lval_nxt      = free_head_r;
        nidx_nxt      = free_head_r;
        state_nxt     = S_SETLK;
      end
      S_FR_RD: begin
        sctl.rd_en = 1'b1;
        state_nxt  = S_FR_WT;
      end
      S_FR_WT: begin
        sctl.data_we  = 1'b1;
        sctl.link_we  = 1'b1;
        s_wr_data     = marker_d;
        s_wr_link     = free_head_r;
        free_head_nxt = cur_r;
        nidx_nxt      = cur_r;
        lval_nxt      = (act_r == clle_pkg::ACT_DEL_REAR) ? clle_pkg::NIL : rd_nl;
        state_nxt     = S_SETLK;
      end
      S_SETLK: begin
        if (prev_r[LW-1]) begin
          for (int k = 0; k < int'(NUM_LISTS); k++) begin
            if (int'(lid_r) == k) begin
              heads_nxt[k] = lval_r;
            end
          end
        end else begin
          sctl.link_we = 1'b1;
          s_wr_addr    = prev_r[AW-1:0];
        end
        state_nxt = S_DONE;
      end
      S_RD_WT: begin
        dout_nxt  = 32'(64'(rd_sdata));
        nxo_nxt   = rd_nl;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hand the result over once the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          ost_nxt       = st_r;
          onidx_nxt     = nidx_r;
          ohead_nxt     = lid_ok ? clle_pkg::norm(head_sel, DEPTH) : clle_pkg::NIL;
          odout_nxt     = dout_r;
          onxt_nxt      = nxo_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      free_head_r <= LW'(DEPTH - 1);
      for (int k = 0; k < int'(NUM_LISTS); k++) begin
        heads_r[k] <= clle_pkg::NIL;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      free_head_r <= free_head_nxt;
      heads_r     <= heads_nxt;
    end
    act_r   <= act_nxt;
    lid_r   <= lid_nxt;
    item_r  <= item_nxt;
    pos_r   <= pos_nxt;
    addr_r  <= addr_nxt;
    cur_r   <= cur_nxt;
    prev_r  <= prev_nxt;
    steps_r <= steps_nxt;
    idx_r   <= idx_nxt;
    lval_r  <= lval_nxt;
    st_r    <= st_nxt;
    nidx_r  <= nidx_nxt;
    dout_r  <= dout_nxt;
    nxo_r   <= nxo_nxt;
    ost_r   <= ost_nxt;
    onidx_r <= onidx_nxt;
    ohead_r <= ohead_nxt;
    odout_r <= odout_nxt;
    onxt_r  <= onxt_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = ost_r;
  assign out_node_index = signed'(onidx_r);
  assign out_list_head  = signed'(ohead_r);
  assign out_data_out   = signed'(odout_r);
  assign out_next_out   = signed'(onxt_r);

  // one action in flight: accepting drops ready on the next cycle
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an action is in flight");

  // a store-full result never names a node
  a_full_no_node: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == clle_pkg::ST_FULL) |-> (out_node_index == -9'sd1))
    else $error("store full result carries a node index");

  // no memory write happens in the wait state that follows a walk read
  a_no_wr_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WAIT) |-> !(sctl.data_we || sctl.link_we))
    else $error("store written during a walk read");

endmodule
`default_nettype wire
